/* sv/assert_macros.svh */
// Assertion macros shared by the running median queue RTL.
// Each macro expands to one labeled concurrent assertion with a disable iff reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* sv/rmq_pkg.sv */
// Package for the running median queue: operation codes, controller states,
// command struct and default sizes. No dependencies.
package rmq_pkg;

   localparam int CAPACITY_DEF    = 64;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int KIND_W          = 2;
   localparam int IO_W            = 32;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

/* sv/rmq_ctrl.sv */
// Controller for the running median queue: item handshake and result valid.
// Depends on rmq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmq_ctrl import rmq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = out_free;
         end
         default: ;
      endcase
   end

   // The result register holds until taken; a new result loads only once it is free.
   assign rsp_valid_in = cmd.execute || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_capture_then_exec, clock, reset, cmd.capture, state_ff == ST_EXEC && req_stall)
   `ASSERT_NEXT(a_exec_waits, clock, reset, state_ff == ST_EXEC && !out_free, state_ff == ST_EXEC)
   `ASSERT_NEXT(a_exec_gives_result, clock, reset, cmd.execute, rsp_valid_ff)

endmodule

/* sv/rmq_datapath.sv */
// Datapath for the running median queue: sorted cell row with parallel
// compare-and-shift, element count and result registers.
// Depends on rmq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmq_datapath import rmq_pkg::*; #(
   parameter  int CAPACITY    = CAPACITY_DEF,
   parameter  int VALUE_WIDTH = VALUE_WIDTH_DEF,
   localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic signed [IO_W-1:0] req_value,
   output logic signed [IO_W-1:0] rsp_median,
   output logic                   rsp_was_empty,
   output logic                   rsp_was_full,
   output logic [CNT_W-1:0]       rsp_count
);

   logic [KIND_W-1:0]             kind_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [63:0]            value_wide;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic signed [VALUE_WIDTH-1:0] cell_ff [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]           gt;
   logic [CAPACITY-1:0]           sel;
   logic [CNT_W-1:0]              mid;
   logic [VALUE_WIDTH-1:0]        median_raw;
   logic signed [63:0]            median_wide;
   logic                          full, empty, is_insert, is_read;
   logic                          do_grow, do_shrink;

   logic signed [IO_W-1:0] median_ff, median_in;
   logic                   was_empty_ff, was_empty_in;
   logic                   was_full_ff, was_full_in;
   logic [CNT_W-1:0]       count_out_ff;

   // The input is sign-extended, then cut to the stored width.
   assign value_wide = 64'(req_value);

   assign full      = count_ff == CNT_W'(CAPACITY);
   assign empty     = count_ff == '0;
   assign is_insert = kind_ff == KIND_INSERT;
   assign is_read   = kind_ff == KIND_REMOVE || kind_ff == KIND_PEEK;
   assign mid       = (count_ff - CNT_W'(1)) >> 1;
   assign do_grow   = cmd.execute && is_insert && !full;
   assign do_shrink = cmd.execute && kind_ff == KIND_REMOVE && !empty;

   // Each cell compares itself with the pending value and flags its median slot.
   // The row is sorted, so gt is a thermometer code above the insert point.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                          prev_gt;
      logic signed [VALUE_WIDTH-1:0] prev_cell;
      logic signed [VALUE_WIDTH-1:0] next_cell;

      assign gt[i]  = (CNT_W'(i) < count_ff) && (cell_ff[i] > value_ff);
      assign sel[i] = CNT_W'(i) == mid;

      if (i == 0) begin : g_first
         assign prev_gt   = 1'b0;
         assign prev_cell = cell_ff[i];
      end else begin : g_mid
         assign prev_gt   = gt[i-1];
         assign prev_cell = cell_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_cell = cell_ff[i];
      end else begin : g_inner
         assign next_cell = cell_ff[i+1];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         case (kind_ff)
            KIND_INSERT: begin
               if (!full) begin
                  if (prev_gt) begin
                     cell_in[i] = prev_cell;
                  end else if (gt[i] || CNT_W'(i) == count_ff) begin
                     cell_in[i] = value_ff;
                  end
               end
            end
            KIND_REMOVE: begin
               if (!empty && CNT_W'(i) >= mid) cell_in[i] = next_cell;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      median_raw = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         median_raw = median_raw | ({VALUE_WIDTH{sel[i]}} & cell_ff[i]);
      end
   end

   assign median_wide = 64'(signed'(median_raw));

   always_comb begin
      count_in = count_ff;
      if (is_insert && !full) begin
         count_in = count_ff + CNT_W'(1);
      end else if (kind_ff == KIND_REMOVE && !empty) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign median_in    = (is_read && !empty) ? median_wide[IO_W-1:0] : '0;
   assign was_empty_in = is_read && empty;
   assign was_full_in  = is_insert && full;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         value_ff <= value_wide[VALUE_WIDTH-1:0];
      end
      if (cmd.execute) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cell_ff[i] <= cell_in[i];
         end
         median_ff    <= median_in;
         was_empty_ff <= was_empty_in;
         was_full_ff  <= was_full_in;
         count_out_ff <= count_in;
      end
   end

   assign rsp_median    = median_ff;
   assign rsp_was_empty = was_empty_ff;
   assign rsp_was_full  = was_full_ff;
   assign rsp_count     = count_out_ff;

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_insert_grows, clock, reset, do_grow, count_ff == $past(count_ff) + CNT_W'(1))
   `ASSERT_NEXT(a_remove_shrinks, clock, reset, do_shrink, count_ff == $past(count_ff) - CNT_W'(1))

endmodule

/* sv/running_median_queue.sv */
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_stall | req_kind, req_value
// rsp      | out       | rsp_valid / rsp_stall | rsp_median, rsp_was_empty, rsp_was_full, rsp_count
//
// Each item is captured first and then executed: the whole cell row compares
// and shifts in parallel and the result register loads in the execute cycle.
// The execute cycle waits while a previous result is still held under rsp_stall.
// Reset is synchronous and empties the store at once; cell contents are not cleared.
// One result item leaves for every accepted item, in order.
// Depends on rmq_pkg, rmq_ctrl and rmq_datapath.
module running_median_queue import rmq_pkg::*; #(
   parameter  int CAPACITY    = CAPACITY_DEF,
   parameter  int VALUE_WIDTH = VALUE_WIDTH_DEF,
   localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic signed [IO_W-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [IO_W-1:0] rsp_median,
   output logic                   rsp_was_empty,
   output logic                   rsp_was_full,
   output logic [CNT_W-1:0]       rsp_count
);

   cmd_type cmd;

   rmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rmq_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_median    (rsp_median),
      .rsp_was_empty (rsp_was_empty),
      .rsp_was_full  (rsp_was_full),
      .rsp_count     (rsp_count)
   );

endmodule
